@@ rtl/tms_pkg.sv @@
// Shared constants and sequencer states for the motion statistics block.
package tms_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int DIST_W  = 40;
    localparam int SPEED_W = 17;
    localparam int COUNT_W = 32;

    localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] MIN_SAMPLES = COUNT_W'(3);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MULX,
        ST_MULY,
        ST_ADD,
        ST_SQRT,
        ST_ACCUM,
        ST_DIV,
        ST_SPEED,
        ST_DONE
    } state_t;

endpackage

@@ rtl/tms_if.sv @@
// Valid/ready channel interfaces for position samples and statistics words.
interface tms_sample_if
    import tms_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          new_track;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic        [TIME_WIDTH-1:0]  time_sec;

    modport source (output valid, new_track, pos_x, pos_y, time_sec, input ready);
    modport sink   (input valid, new_track, pos_x, pos_y, time_sec, output ready);
endinterface

interface tms_stats_if
    import tms_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  total_distance;
    logic [SPEED_W-1:0] max_speed;
    logic [SPEED_W-1:0] largest_slowdown;
    logic [COUNT_W-1:0] sample_count;
    logic               has_slowdown;

    modport source (output valid, total_distance, max_speed, largest_slowdown,
                    sample_count, has_slowdown, input ready);
    modport sink   (input valid, total_distance, max_speed, largest_slowdown,
                    sample_count, has_slowdown, output ready);
endinterface

@@ rtl/track_motion_statistics.sv @@
// Running path length, peak speed and slowdown statistics over a sample track.
//
// sample channel: one word per timestamped position (new_track, pos_x, pos_y,
// time_sec). stats channel: one word per sample with the running totals since
// reset or the last new_track mark.
// Each sample is worked through by a sequencer around one shared squarer and
// one shared compare/subtract unit. The segment length is formed in the
// difference, square-x, square-y and add steps, then by a restoring square
// root of COORD_WIDTH+1 root bits. When time advances, a restoring divide of
// COORD_WIDTH+1 quotient bits gives the speed; single steps add the length,
// update the speed statistics and load the stats word. When time does not
// advance the divide and speed update are skipped, and the first sample of a
// track goes straight to the stats word. sample.ready is high only while the
// sequencer is idle, so a new sample can be accepted the cycle after the
// previous stats word is registered.
// The stats word sits in an output register; while the receiver stalls, the
// next sample may be accepted and worked through, and waits in its final step
// until the register is free.
// Reset clears all statistics and the stored previous sample, and empties
// the output register.
module track_motion_statistics
    import tms_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    tms_sample_if.sink   sample,
    tms_stats_if.source  stats
);

    localparam int ROOTW = COORD_WIDTH + 1;
    localparam int RADW  = 2 * ROOTW;
    localparam int SUBW  = (ROOTW + 2 > TIME_WIDTH + 1) ? ROOTW + 2 : TIME_WIDTH + 1;
    localparam int QW    = (ROOTW > SPEED_W) ? ROOTW : SPEED_W;
    localparam int CNTW  = $clog2(ROOTW);

    state_t state_reg, state_next;

    // latched sample
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg;
    logic        [TIME_WIDTH-1:0]  t_reg;

    // previous sample and running statistics
    logic signed [COORD_WIDTH-1:0] last_x_reg, last_y_reg;
    logic        [TIME_WIDTH-1:0]  last_t_reg;
    logic        [SPEED_W-1:0]     prev_speed_reg;
    logic                          speed_seen_reg;
    logic        [DIST_W-1:0]      dist_reg;
    logic        [SPEED_W-1:0]     peak_reg;
    logic        [SPEED_W-1:0]     drop_reg;
    logic        [COUNT_W-1:0]     count_reg;

    // working registers
    logic [ROOTW-1:0]      ax_reg, ay_reg;
    logic [RADW-1:0]       prod_reg, rad_reg;
    logic [ROOTW+1:0]      srem_reg;
    logic [ROOTW-1:0]      root_reg;
    logic [TIME_WIDTH-1:0] dt_reg, drem_reg;
    logic [ROOTW-1:0]      quo_reg;
    logic [CNTW-1:0]       cnt_reg;

    // output register
    logic               out_valid_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic [SPEED_W-1:0] out_peak_reg, out_drop_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_slow_reg;

    // sequencer outputs
    logic             accept;
    logic             out_load;
    logic [ROOTW-1:0] mul_a;
    logic [SUBW-1:0]  sub_a, sub_b;

    // shared units
    logic [RADW-1:0]  mul_out;
    logic [SUBW:0]    sub_diff;
    logic             sub_ge;

    logic                   iter_last;
    logic                   time_fwd;
    logic signed [ROOTW-1:0] dx, dy;
    logic [ROOTW+1:0]       sqrt_sh;
    logic [TIME_WIDTH:0]    div_sh;
    logic [DIST_W:0]        dist_sum;
    logic [QW-1:0]          quo_ext;
    logic [SPEED_W-1:0]     speed;
    logic [COUNT_W-1:0]     count_next;

    assign mul_out  = RADW'(mul_a) * RADW'(mul_a);
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[SUBW];

    assign iter_last = (cnt_reg == CNTW'(ROOTW - 1));
    assign time_fwd  = (t_reg > last_t_reg);
    assign dx = $signed({x_reg[COORD_WIDTH-1], x_reg}) -
                $signed({last_x_reg[COORD_WIDTH-1], last_x_reg});
    assign dy = $signed({y_reg[COORD_WIDTH-1], y_reg}) -
                $signed({last_y_reg[COORD_WIDTH-1], last_y_reg});
    assign sqrt_sh  = {srem_reg[ROOTW-1:0], rad_reg[RADW-1:RADW-2]};
    assign div_sh   = {drem_reg, quo_reg[ROOTW-1]};
    assign dist_sum = {1'b0, dist_reg} + (DIST_W+1)'(root_reg);
    assign quo_ext  = QW'(quo_reg);
    assign speed    = (quo_ext > QW'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(quo_ext);
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    if (sample.new_track || count_reg == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_MULX;
            ST_MULX:  state_next = ST_MULY;
            ST_MULY:  state_next = ST_ADD;
            ST_ADD:   state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (iter_last)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM: state_next = time_fwd ? ST_DIV : ST_DONE;
            ST_DIV:
            begin
                if (iter_last)
                    state_next = ST_SPEED;
            end
            ST_SPEED: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || stats.ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and operand selection for the shared units
    always_comb
    begin
        sample.ready = 1'b0;
        out_load     = 1'b0;
        mul_a        = ax_reg;
        sub_a        = SUBW'(sqrt_sh);
        sub_b        = SUBW'({root_reg, 2'b01});
        case (state_reg)
            ST_IDLE: sample.ready = 1'b1;
            ST_MULY: mul_a = ay_reg;
            ST_DIV:
            begin
                sub_a = SUBW'(div_sh);
                sub_b = SUBW'(dt_reg);
            end
            ST_DONE: out_load = !out_valid_reg || stats.ready;
            default: ;
        endcase
    end

    assign accept = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample.pos_x;
            y_reg <= sample.pos_y;
            t_reg <= sample.time_sec;
        end
        case (state_reg)
            ST_DIFF:
            begin
                ax_reg <= dx[ROOTW-1] ? ROOTW'(-dx) : ROOTW'(dx);
                ay_reg <= dy[ROOTW-1] ? ROOTW'(-dy) : ROOTW'(dy);
            end
            ST_MULX: prod_reg <= mul_out;
            ST_MULY:
            begin
                rad_reg  <= prod_reg;
                prod_reg <= mul_out;
            end
            ST_ADD:
            begin
                rad_reg  <= rad_reg + prod_reg;
                srem_reg <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                rad_reg  <= {rad_reg[RADW-3:0], 2'b00};
                srem_reg <= sub_ge ? sub_diff[ROOTW+1:0] : sqrt_sh;
                root_reg <= {root_reg[ROOTW-2:0], sub_ge};
                cnt_reg  <= cnt_reg + CNTW'(1);
            end
            ST_ACCUM:
            begin
                dt_reg   <= t_reg - last_t_reg;
                drem_reg <= '0;
                quo_reg  <= root_reg;
                cnt_reg  <= '0;
            end
            ST_DIV:
            begin
                // shift the dividend out of the top as quotient bits come in
                drem_reg <= sub_ge ? sub_diff[TIME_WIDTH-1:0] : div_sh[TIME_WIDTH-1:0];
                quo_reg  <= {quo_reg[ROOTW-2:0], sub_ge};
                cnt_reg  <= cnt_reg + CNTW'(1);
            end
            default: ;
        endcase
    end

    // running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_t_reg     <= '0;
            prev_speed_reg <= '0;
            speed_seen_reg <= 1'b0;
            dist_reg       <= '0;
            peak_reg       <= '0;
            drop_reg       <= '0;
            count_reg      <= '0;
        end
        else if (accept && sample.new_track)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_t_reg     <= '0;
            prev_speed_reg <= '0;
            speed_seen_reg <= 1'b0;
            dist_reg       <= '0;
            peak_reg       <= '0;
            drop_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_ACCUM:
                    dist_reg <= dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
                ST_SPEED:
                begin
                    if (speed > peak_reg)
                        peak_reg <= speed;
                    if (speed_seen_reg && prev_speed_reg > speed &&
                        (prev_speed_reg - speed) > drop_reg)
                        drop_reg <= prev_speed_reg - speed;
                    prev_speed_reg <= speed;
                    speed_seen_reg <= 1'b1;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        last_x_reg <= x_reg;
                        last_y_reg <= y_reg;
                        last_t_reg <= t_reg;
                        count_reg  <= count_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (stats.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dist_reg  <= dist_reg;
            out_peak_reg  <= peak_reg;
            out_drop_reg  <= drop_reg;
            out_count_reg <= count_next;
            out_slow_reg  <= (count_next >= MIN_SAMPLES) && (drop_reg != '0);
        end
    end

    assign stats.valid            = out_valid_reg;
    assign stats.total_distance   = out_dist_reg;
    assign stats.max_speed        = out_peak_reg;
    assign stats.largest_slowdown = out_drop_reg;
    assign stats.sample_count     = out_count_reg;
    assign stats.has_slowdown     = out_slow_reg;

endmodule

@@ rtl/tms_checker.sv @@
// Port-level checks for the motion statistics block, bound to the top level.
module tms_checker
    import tms_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [DIST_W-1:0]  total_distance,
    input logic [SPEED_W-1:0] max_speed,
    input logic [SPEED_W-1:0] largest_slowdown,
    input logic [COUNT_W-1:0] sample_count,
    input logic               has_slowdown
);

    // one sample at a time: the sequencer is busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while the previous one is still in work");

    a_slowdown_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_slowdown |-> sample_count >= MIN_SAMPLES)
        else $error("slowdown flagged with fewer than three samples");

    a_drop_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> largest_slowdown <= max_speed)
        else $error("largest slowdown exceeds peak speed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_distance)
                                    && $stable(sample_count))
        else $error("stalled stats word changed or dropped");

endmodule

bind track_motion_statistics tms_checker u_tms_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (sample.valid),
    .in_ready         (sample.ready),
    .out_valid        (stats.valid),
    .out_ready        (stats.ready),
    .total_distance   (stats.total_distance),
    .max_speed        (stats.max_speed),
    .largest_slowdown (stats.largest_slowdown),
    .sample_count     (stats.sample_count),
    .has_slowdown     (stats.has_slowdown)
);
